// ===== rtl/pid_difference_equation_controller_unit_macros.svh =====
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef PID_DIFFERENCE_EQUATION_CONTROLLER_UNIT_MACROS_SVH
`define PID_DIFFERENCE_EQUATION_CONTROLLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define PDC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("pdc check failed");

`define PDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("pdc check failed");

`else

`define PDC_ASSERT_SAME(lbl, ante, cons)

`define PDC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/pdc_pkg.sv =====
`timescale 1ns / 1ps

package pdc_pkg;

	localparam int ADC_W = 10;
	localparam int REF_W = 18;
	localparam int DRIVE_W = 19;
	localparam int DUTY_W = 7;
	localparam int CMP_W = 12;
	localparam int COEF_W = 16;
	localparam int SIG_W = 24;
	localparam int PROD_W = 40;
	localparam int ACC_W = 44;
	localparam int SCALE_W = 24;
	localparam int PERIOD_W = 17;
	localparam int RECIP_W = 26;
	localparam int RECIP_SHIFT = 32;
	localparam int CFG_INDEX_W = 4;
	localparam int STEP_W = 5;

	localparam logic [CFG_INDEX_W-1:0] REG_COUNT = 4'd8;
	localparam logic [STEP_W-1:0] STEP_IDLE = 5'd0;
	localparam logic [STEP_W-1:0] STEP_OUT = 5'd16;

	localparam logic signed [ACC_W-1:0] SIG_MAX = 44'sd8388607;
	localparam logic signed [ACC_W-1:0] SIG_MIN = -44'sd8388608;
	localparam logic signed [SIG_W-1:0] FULL_SCALE = 24'sd262144;
	localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;
	localparam logic [RECIP_W-1:0] DIV100_RECIP = 26'd42949673;

	typedef struct packed {
		logic [ADC_W-1:0] adc_sample;
		logic [REF_W-1:0] reference_level;
	} sample_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] drive_level;
		logic [DUTY_W-1:0] duty_percent;
		logic [CMP_W-1:0] compare_value;
	} result_t;

	typedef enum logic [2:0] {
		C_PRE_NOW,
		C_PRE_PAST,
		C_PRE_FEEDBACK,
		C_ERR_NOW,
		C_ERR_ONE,
		C_ERR_TWO,
		C_DRV_ONE,
		C_DRV_TWO
	} coef_sel_t;

	typedef enum logic [2:0] {
		OPD_REF,
		OPD_REF1,
		OPD_FREF1,
		OPD_EF,
		OPD_E1,
		OPD_E2,
		OPD_D1,
		OPD_D2
	} opd_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_RF,
		WR_EF,
		WR_DRIVE,
		WR_DUTY,
		WR_SCALE,
		WR_OUT
	} wr_op_t;

	typedef enum logic [1:0] {
		JMP_NEVER,
		JMP_NO_SAMPLE,
		JMP_OUT_BUSY
	} jmp_cond_t;

	typedef struct packed {
		logic mul_en;
		coef_sel_t coef_sel;
		opd_sel_t opd_sel;
		acc_op_t acc_op;
		wr_op_t wr_op;
		jmp_cond_t jmp_cond;
		logic [STEP_W-1:0] jmp_target;
		logic last;
	} ucode_t;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t uc;
		uc.mul_en = 1'b0;
		uc.coef_sel = C_PRE_NOW;
		uc.opd_sel = OPD_REF;
		uc.acc_op = ACC_HOLD;
		uc.wr_op = WR_NONE;
		uc.jmp_cond = JMP_NEVER;
		uc.jmp_target = STEP_IDLE;
		uc.last = 1'b0;
		case (step)
			5'd0: begin
				uc.jmp_cond = JMP_NO_SAMPLE;
				uc.jmp_target = STEP_IDLE;
			end
			5'd1: begin
				uc.mul_en = 1'b1;
				uc.coef_sel = C_PRE_NOW;
				uc.opd_sel = OPD_REF;
			end
			5'd2: begin
				uc.mul_en = 1'b1;
				uc.coef_sel = C_PRE_PAST;
				uc.opd_sel = OPD_REF1;
				uc.acc_op = ACC_LOAD;
			end
			5'd3: begin
				uc.mul_en = 1'b1;
				uc.coef_sel = C_PRE_FEEDBACK;
				uc.opd_sel = OPD_FREF1;
				uc.acc_op = ACC_ADD;
			end
			5'd4: begin
				uc.acc_op = ACC_SUB;
			end
			5'd5: begin
				uc.wr_op = WR_RF;
			end
			5'd6: begin
				uc.wr_op = WR_EF;
			end
			5'd7: begin
				uc.mul_en = 1'b1;
				uc.coef_sel = C_ERR_NOW;
				uc.opd_sel = OPD_EF;
			end
			5'd8: begin
				uc.mul_en = 1'b1;
				uc.coef_sel = C_ERR_ONE;
				uc.opd_sel = OPD_E1;
				uc.acc_op = ACC_LOAD;
			end
			5'd9: begin
				uc.mul_en = 1'b1;
				uc.coef_sel = C_ERR_TWO;
				uc.opd_sel = OPD_E2;
				uc.acc_op = ACC_ADD;
			end
			5'd10: begin
				uc.mul_en = 1'b1;
				uc.coef_sel = C_DRV_ONE;
				uc.opd_sel = OPD_D1;
				uc.acc_op = ACC_ADD;
			end
			5'd11: begin
				uc.mul_en = 1'b1;
				uc.coef_sel = C_DRV_TWO;
				uc.opd_sel = OPD_D2;
				uc.acc_op = ACC_SUB;
			end
			5'd12: begin
				uc.acc_op = ACC_SUB;
			end
			5'd13: begin
				uc.wr_op = WR_DRIVE;
			end
			5'd14: begin
				uc.wr_op = WR_DUTY;
			end
			5'd15: begin
				uc.wr_op = WR_SCALE;
			end
			5'd16: begin
				uc.wr_op = WR_OUT;
				uc.jmp_cond = JMP_OUT_BUSY;
				uc.jmp_target = STEP_OUT;
				uc.last = 1'b1;
			end
			default: begin
				uc.last = 1'b1;
			end
		endcase
		return uc;
	endfunction

	function automatic logic signed [SIG_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
		logic signed [SIG_W-1:0] r;
		if (v > SIG_MAX) begin
			r = SIG_MAX[SIG_W-1:0];
		end else if (v < SIG_MIN) begin
			r = SIG_MIN[SIG_W-1:0];
		end else begin
			r = v[SIG_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/pid_difference_equation_controller_unit.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake                payload
// sample    in         sample_valid/stall       sample_t (adc_sample, reference_level)
// result    out        result_valid/stall       result_t (drive_level, duty_percent,
//                                               compare_value)
// cfg       in         cfg_valid/cfg_ready      cfg_index (register number), cfg_data
//
// For each sample, a microcode step counter runs all eight coefficient
// products through a single 16x24 multiplier and accumulator, one product per step.
// The result register is loaded in the last step; a stalled result holds that step.
// A new sample is taken once the counter is back at step zero.
// Reset clears coefficients, history and the result valid flag; no clearing pass.
`include "pid_difference_equation_controller_unit_macros.svh"

module pid_difference_equation_controller_unit
	import pdc_pkg::*;
#(
	parameter int PWM_TOP = 2499,
	parameter int COEF_FRAC_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  sample_t                sample,
	output logic                   result_valid,
	input  logic                   result_stall,
	output result_t                result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]      cfg_data
);

	localparam logic [PERIOD_W-1:0] PWM_PERIOD = PERIOD_W'(PWM_TOP + 1);

	logic [STEP_W-1:0] step_q;
	ucode_t uc;
	logic jump;
	logic sample_xfer;

	logic signed [COEF_W-1:0] coef_q [8];
	logic [ADC_W-1:0] adc_q;
	logic [REF_W-1:0] ref_q;

	logic signed [SIG_W-1:0] err1_q, err2_q, drv1_q, drv2_q, ref1_q, fref1_q;
	logic signed [SIG_W-1:0] rf_q, ef_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [DRIVE_W-1:0] drive_q;
	logic [DUTY_W-1:0] duty_q;
	logic [SCALE_W-1:0] scale_q;

	logic result_valid_q;
	result_t result_q;

	logic signed [SIG_W-1:0] opd;
	logic signed [ACC_W-1:0] prod_ext;
	logic signed [ACC_W-1:0] acc_shifted;
	logic signed [SIG_W-1:0] acc_sat;
	logic signed [ACC_W-1:0] y_ext;
	logic signed [ACC_W-1:0] ef_diff;
	logic signed [ACC_W-1:0] err_diff;
	logic [DRIVE_W-1:0] drive_clamped;
	logic [DRIVE_W+DUTY_W-1:0] duty_prod;
	logic [DRIVE_W+DUTY_W-REF_W-1:0] duty_raw;
	logic [SCALE_W+RECIP_W-1:0] cmp_prod;

	assign uc = ucode_rom(step_q);
	assign sample_stall = (step_q != STEP_IDLE);
	assign sample_xfer = sample_valid && !sample_stall;
	assign cfg_ready = 1'b1;
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_comb begin
		case (uc.jmp_cond)
			JMP_NO_SAMPLE: jump = !sample_valid;
			JMP_OUT_BUSY:  jump = result_valid_q && result_stall;
			default:       jump = 1'b0;
		endcase
	end

	always_comb begin
		case (uc.opd_sel)
			OPD_REF:   opd = SIG_W'(signed'({1'b0, ref_q}));
			OPD_REF1:  opd = ref1_q;
			OPD_FREF1: opd = fref1_q;
			OPD_EF:    opd = ef_q;
			OPD_E1:    opd = err1_q;
			OPD_E2:    opd = err2_q;
			OPD_D1:    opd = drv1_q;
			OPD_D2:    opd = drv2_q;
			default:   opd = '0;
		endcase
	end

	assign prod_ext = ACC_W'(prod_q);
	assign acc_shifted = acc_q >>> COEF_FRAC_BITS;
	assign acc_sat = sat24(acc_shifted);
	assign y_ext = ACC_W'(signed'({1'b0, adc_q, 8'd0}));
	assign ef_diff = ACC_W'(rf_q) - y_ext;
	assign err_diff = ACC_W'(signed'({1'b0, ref_q})) - y_ext;

	always_comb begin
		if (acc_sat > FULL_SCALE) begin
			drive_clamped = FULL_SCALE[DRIVE_W-1:0];
		end else if (acc_sat < 0) begin
			drive_clamped = '0;
		end else begin
			drive_clamped = acc_sat[DRIVE_W-1:0];
		end
	end

	assign duty_prod = (DRIVE_W + DUTY_W)'(drive_q) * (DRIVE_W + DUTY_W)'(DUTY_MAX);
	assign duty_raw = duty_prod[DRIVE_W+DUTY_W-1:REF_W];
	assign cmp_prod = (SCALE_W + RECIP_W)'(scale_q) * (SCALE_W + RECIP_W)'(DIV100_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready && (cfg_index < REG_COUNT)) begin
			coef_q[cfg_index[2:0]] <= signed'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
			result_valid_q <= 1'b0;
			err1_q <= '0;
			err2_q <= '0;
			drv1_q <= '0;
			drv2_q <= '0;
			ref1_q <= '0;
			fref1_q <= '0;
		end else begin
			if (jump) begin
				step_q <= uc.jmp_target;
			end else if (uc.last) begin
				step_q <= STEP_IDLE;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
			if (!jump && (uc.wr_op == WR_OUT)) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (!jump) begin
				case (uc.wr_op)
					WR_DRIVE: begin
						err2_q <= err1_q;
						err1_q <= sat24(err_diff);
						drv2_q <= drv1_q;
						drv1_q <= SIG_W'(signed'({1'b0, drive_clamped}));
						ref1_q <= SIG_W'(signed'({1'b0, ref_q}));
						fref1_q <= rf_q;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_xfer) begin
			adc_q <= sample.adc_sample;
			ref_q <= sample.reference_level;
		end
		if (uc.mul_en) begin
			prod_q <= PROD_W'(coef_q[uc.coef_sel]) * PROD_W'(opd);
		end
		case (uc.acc_op)
			ACC_LOAD: acc_q <= prod_ext;
			ACC_ADD:  acc_q <= acc_q + prod_ext;
			ACC_SUB:  acc_q <= acc_q - prod_ext;
			default:  acc_q <= acc_q;
		endcase
		if (!jump) begin
			case (uc.wr_op)
				WR_RF:    rf_q <= acc_sat;
				WR_EF:    ef_q <= sat24(ef_diff);
				WR_DRIVE: drive_q <= drive_clamped;
				WR_DUTY: begin
					if (duty_raw > (DRIVE_W + DUTY_W - REF_W)'(DUTY_MAX)) begin
						duty_q <= DUTY_MAX;
					end else begin
						duty_q <= duty_raw[DUTY_W-1:0];
					end
				end
				WR_SCALE: scale_q <= SCALE_W'(duty_q) * SCALE_W'(PWM_PERIOD);
				WR_OUT: begin
					result_q.drive_level <= drive_q;
					result_q.duty_percent <= duty_q;
					result_q.compare_value <= cmp_prod[RECIP_SHIFT+CMP_W-1:RECIP_SHIFT];
				end
				default: begin
				end
			endcase
		end
	end

	`PDC_ASSERT_NEXT(a_take_starts, sample_valid && !sample_stall, step_q == 5'd1)
	`PDC_ASSERT_NEXT(a_out_loads, (step_q == STEP_OUT) && !(result_valid && result_stall), result_valid && (step_q == STEP_IDLE))
	`PDC_ASSERT_SAME(a_out_range, result_valid, (result.drive_level <= 19'd262144) && (result.duty_percent <= DUTY_MAX))
	`PDC_ASSERT_SAME(a_step_range, 1'b1, step_q <= STEP_OUT)
	`PDC_ASSERT_NEXT(a_busy_holds, result_valid && result_stall && (step_q == STEP_OUT), step_q == STEP_OUT)

endmodule
